// ----- sv/rc4_pkg.sv -----
// Shared types and constants for the RC4 stream cipher block.
`default_nettype none

package rc4_pkg;

  localparam int BYTE_W     = 8;
  localparam int KEY_WORD_W = 64;
  localparam int KEY_WORDS  = 4;
  localparam int KEY_FLAT_W = KEY_WORD_W * KEY_WORDS;
  localparam int KEY_LEN_W  = 6;
  localparam int KEY_IDX_W  = 5;
  localparam int CFG_IDX_W  = 3;

  localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 6'd16;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD1  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD2  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD3  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_KS_RD_N,
    ST_KS_RD_J,
    ST_KS_WR_N,
    ST_KS_WR_J,
    ST_PG_RD_I,
    ST_PG_RD_J,
    ST_PG_RD_T,
    ST_PG_OUT
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_FILL,
    OP_KS_RD_N,
    OP_KS_RD_J,
    OP_KS_WR_N,
    OP_KS_WR_J,
    OP_PG_RD_I,
    OP_PG_RD_J,
    OP_PG_RD_T,
    OP_PG_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   out_load;
  } cmd_t;

  typedef struct packed {
    logic need_ks;
    logic n_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ----- sv/rc4_stream_cipher.sv -----
// Top level of the RC4 stream cipher: sequencer plus datapath.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid/in_ready    in_data_byte[7:0], in_start_message
//   out_     output     out_valid/out_ready  out_out_byte[7:0], out_keystream_byte[7:0]
//   cfg_     input      cfg_we               cfg_index[2:0], cfg_wdata[63:0]
//
// An item takes the accept step, then four S-box memory steps on a memory with one
// read and one write port (read S[i], read S[j], swap write plus read S[t], final write).
// A message start, or the first item after reset, adds a key schedule: a fill of
// all 256 S-box entries, then read S[n], read S[j], write S[n], write S[j] per entry.
// Synchronous active-low reset; the S-box has no reset and is rebuilt by the
// key schedule. A stalled output holds the block in its final step; the next
// item is accepted while the previous result waits in the output register.
`default_nettype none

module rc4_stream_cipher #(
  parameter int MAX_KEY_BYTES = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [rc4_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [rc4_pkg::KEY_WORD_W-1:0]  cfg_wdata,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [rc4_pkg::BYTE_W-1:0]      in_data_byte,
  input  wire logic                            in_start_message,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [rc4_pkg::BYTE_W-1:0]           out_out_byte,
  output logic [rc4_pkg::BYTE_W-1:0]           out_keystream_byte
);

  rc4_pkg::cmd_t cmd;
  rc4_pkg::sts_t sts;

  rc4_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rc4_dp #(
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_data_byte       (in_data_byte),
    .in_start_message   (in_start_message),
    .cmd                (cmd),
    .sts                (sts),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_out_byte       (out_out_byte),
    .out_keystream_byte (out_keystream_byte)
  );

endmodule

`default_nettype wire

// ----- sv/rc4_ctrl.sv -----
// Sequencer for S-box fill, key schedule and keystream generation.
`default_nettype none

module rc4_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire rc4_pkg::sts_t sts,
  output rc4_pkg::cmd_t      cmd
);

  rc4_pkg::state_t state_r;
  rc4_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rc4_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rc4_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = sts.need_ks ? rc4_pkg::ST_FILL : rc4_pkg::ST_PG_RD_I;
        end
      end
      rc4_pkg::ST_FILL: begin
        if (sts.n_last) begin
          state_nxt = rc4_pkg::ST_KS_RD_N;
        end
      end
      rc4_pkg::ST_KS_RD_N: state_nxt = rc4_pkg::ST_KS_RD_J;
      rc4_pkg::ST_KS_RD_J: state_nxt = rc4_pkg::ST_KS_WR_N;
      rc4_pkg::ST_KS_WR_N: state_nxt = rc4_pkg::ST_KS_WR_J;
      rc4_pkg::ST_KS_WR_J: begin
        state_nxt = sts.n_last ? rc4_pkg::ST_PG_RD_I : rc4_pkg::ST_KS_RD_N;
      end
      rc4_pkg::ST_PG_RD_I: state_nxt = rc4_pkg::ST_PG_RD_J;
      rc4_pkg::ST_PG_RD_J: state_nxt = rc4_pkg::ST_PG_RD_T;
      rc4_pkg::ST_PG_RD_T: state_nxt = rc4_pkg::ST_PG_OUT;
      rc4_pkg::ST_PG_OUT: begin
        if (sts.out_free) begin
          state_nxt = rc4_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rc4_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.op       = rc4_pkg::OP_NONE;
    cmd.out_load = 1'b0;
    in_ready     = 1'b0;
    case (state_r)
      rc4_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = rc4_pkg::OP_LOAD;
        end
      end
      rc4_pkg::ST_FILL:    cmd.op = rc4_pkg::OP_FILL;
      rc4_pkg::ST_KS_RD_N: cmd.op = rc4_pkg::OP_KS_RD_N;
      rc4_pkg::ST_KS_RD_J: cmd.op = rc4_pkg::OP_KS_RD_J;
      rc4_pkg::ST_KS_WR_N: cmd.op = rc4_pkg::OP_KS_WR_N;
      rc4_pkg::ST_KS_WR_J: cmd.op = rc4_pkg::OP_KS_WR_J;
      rc4_pkg::ST_PG_RD_I: cmd.op = rc4_pkg::OP_PG_RD_I;
      rc4_pkg::ST_PG_RD_J: cmd.op = rc4_pkg::OP_PG_RD_J;
      rc4_pkg::ST_PG_RD_T: cmd.op = rc4_pkg::OP_PG_RD_T;
      rc4_pkg::ST_PG_OUT: begin
        cmd.op       = rc4_pkg::OP_PG_OUT;
        cmd.out_load = sts.out_free;
      end
      default: cmd.op = rc4_pkg::OP_NONE;
    endcase
  end

`ifndef NO_ASSERTIONS
  // keystream step starts only from an accepted item or a finished key schedule
  a_pg_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rc4_pkg::ST_PG_RD_I) |->
      ($past(state_r) == rc4_pkg::ST_IDLE || $past(state_r) == rc4_pkg::ST_KS_WR_J))
    else $error("keystream step entered from wrong state");

  a_fill_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rc4_pkg::ST_FILL) |->
      ($past(state_r) == rc4_pkg::ST_IDLE || $past(state_r) == rc4_pkg::ST_FILL))
    else $error("S-box fill entered from wrong state");
`endif

endmodule

`default_nettype wire

// ----- sv/rc4_dp.sv -----
// Datapath: key registers, S-box memory, indices and output register.
`default_nettype none

module rc4_dp #(
  parameter int MAX_KEY_BYTES = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [rc4_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [rc4_pkg::KEY_WORD_W-1:0]  cfg_wdata,
  input  wire logic [rc4_pkg::BYTE_W-1:0]      in_data_byte,
  input  wire logic                            in_start_message,
  input  wire rc4_pkg::cmd_t                   cmd,
  output rc4_pkg::sts_t                        sts,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [rc4_pkg::BYTE_W-1:0]           out_out_byte,
  output logic [rc4_pkg::BYTE_W-1:0]           out_keystream_byte
);

  localparam int KPW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam logic [rc4_pkg::KEY_LEN_W-1:0] MAX_LEN = rc4_pkg::KEY_LEN_W'(MAX_KEY_BYTES);

  logic [rc4_pkg::BYTE_W-1:0] sbox_mem [256];
  logic [rc4_pkg::BYTE_W-1:0] rdata_r;
  logic                       mem_we;
  logic [rc4_pkg::BYTE_W-1:0] mem_waddr;
  logic [rc4_pkg::BYTE_W-1:0] mem_wdata;
  logic [rc4_pkg::BYTE_W-1:0] mem_raddr;

  logic [rc4_pkg::KEY_FLAT_W-1:0] key_flat_r;
  logic [rc4_pkg::KEY_LEN_W-1:0]  key_len_r;
  logic [rc4_pkg::KEY_LEN_W-1:0]  len_eff;
  logic [rc4_pkg::KEY_LEN_W-1:0]  pos_inc;
  logic [KPW-1:0]                 pos_wrap;
  logic [rc4_pkg::BYTE_W-1:0]     key_byte;

  logic [rc4_pkg::BYTE_W-1:0] n_r, n_nxt;
  logic [rc4_pkg::BYTE_W-1:0] i_r, i_nxt;
  logic [rc4_pkg::BYTE_W-1:0] j_r, j_nxt;
  logic [rc4_pkg::BYTE_W-1:0] sn_r, sn_nxt;
  logic [rc4_pkg::BYTE_W-1:0] sj_r, sj_nxt;
  logic [rc4_pkg::BYTE_W-1:0] t_r, t_nxt;
  logic [rc4_pkg::BYTE_W-1:0] data_r, data_nxt;
  logic [KPW-1:0]             pos_r, pos_nxt;
  logic                       keyed_r, keyed_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [rc4_pkg::BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic [rc4_pkg::BYTE_W-1:0] ks_r, ks_nxt;

  logic [rc4_pkg::BYTE_W-1:0] j_ks;
  logic [rc4_pkg::BYTE_W-1:0] j_pg;
  logic [rc4_pkg::BYTE_W-1:0] t_sum;
  logic [rc4_pkg::BYTE_W-1:0] ks_val;

  // zero length acts as one, longer keys saturate
  always_comb begin
    if (key_len_r == '0) begin
      len_eff = rc4_pkg::KEY_LEN_W'(1);
    end else if (key_len_r > MAX_LEN) begin
      len_eff = MAX_LEN;
    end else begin
      len_eff = key_len_r;
    end
  end

  assign pos_inc  = rc4_pkg::KEY_LEN_W'(pos_r) + rc4_pkg::KEY_LEN_W'(1);
  assign pos_wrap = (pos_inc >= len_eff) ? '0 : KPW'(pos_inc);
  assign key_byte = key_flat_r[{rc4_pkg::KEY_IDX_W'(pos_r), 3'b000} +: rc4_pkg::BYTE_W];

  assign j_ks  = j_r + rdata_r + key_byte;
  assign j_pg  = j_r + rdata_r;
  assign t_sum = sn_r + rdata_r;

  // S[t] was read while S[i] was being written and before S[j] was: forward swapped values
  always_comb begin
    if (t_r == j_r) begin
      ks_val = sn_r;
    end else if (t_r == i_r) begin
      ks_val = sj_r;
    end else begin
      ks_val = rdata_r;
    end
  end

  always_comb begin
    n_nxt        = n_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    sn_nxt       = sn_r;
    sj_nxt       = sj_r;
    t_nxt        = t_r;
    data_nxt     = data_r;
    pos_nxt      = pos_r;
    keyed_nxt    = keyed_r;
    out_byte_nxt = out_byte_r;
    ks_nxt       = ks_r;
    mem_we       = 1'b0;
    mem_waddr    = n_r;
    mem_wdata    = rdata_r;
    mem_raddr    = t_r;
    case (cmd.op)
      rc4_pkg::OP_LOAD: begin
        data_nxt = in_data_byte;
        n_nxt    = '0;
      end
      rc4_pkg::OP_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = n_r;
        mem_wdata = n_r;
        n_nxt     = n_r + 8'd1;
        j_nxt     = '0;
        pos_nxt   = '0;
      end
      rc4_pkg::OP_KS_RD_N: begin
        mem_raddr = n_r;
      end
      rc4_pkg::OP_KS_RD_J: begin
        mem_raddr = j_ks;
        j_nxt     = j_ks;
        sn_nxt    = rdata_r;
      end
      rc4_pkg::OP_KS_WR_N: begin
        mem_we    = 1'b1;
        mem_waddr = n_r;
        mem_wdata = rdata_r;
      end
      rc4_pkg::OP_KS_WR_J: begin
        mem_we    = 1'b1;
        mem_waddr = j_r;
        mem_wdata = sn_r;
        n_nxt     = n_r + 8'd1;
        pos_nxt   = pos_wrap;
        if (sts.n_last) begin
          i_nxt     = '0;
          j_nxt     = '0;
          keyed_nxt = 1'b1;
        end
      end
      rc4_pkg::OP_PG_RD_I: begin
        mem_raddr = i_r + 8'd1;
        i_nxt     = i_r + 8'd1;
      end
      rc4_pkg::OP_PG_RD_J: begin
        mem_raddr = j_pg;
        j_nxt     = j_pg;
        sn_nxt    = rdata_r;
      end
      rc4_pkg::OP_PG_RD_T: begin
        mem_we    = 1'b1;
        mem_waddr = i_r;
        mem_wdata = rdata_r;
        sj_nxt    = rdata_r;
        mem_raddr = t_sum;
        t_nxt     = t_sum;
      end
      rc4_pkg::OP_PG_OUT: begin
        mem_we    = 1'b1;
        mem_waddr = j_r;
        mem_wdata = sn_r;
        mem_raddr = t_r;
        if (cmd.out_load) begin
          out_byte_nxt = data_r ^ ks_val;
          ks_nxt       = ks_val;
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      sbox_mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= sbox_mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_flat_r  <= '0;
      key_len_r   <= rc4_pkg::KEY_LEN_RESET;
      i_r         <= '0;
      j_r         <= '0;
      keyed_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      keyed_r     <= keyed_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          rc4_pkg::REG_KEY_WORD0:  key_flat_r[0*rc4_pkg::KEY_WORD_W +: rc4_pkg::KEY_WORD_W] <= cfg_wdata;
          rc4_pkg::REG_KEY_WORD1:  key_flat_r[1*rc4_pkg::KEY_WORD_W +: rc4_pkg::KEY_WORD_W] <= cfg_wdata;
          rc4_pkg::REG_KEY_WORD2:  key_flat_r[2*rc4_pkg::KEY_WORD_W +: rc4_pkg::KEY_WORD_W] <= cfg_wdata;
          rc4_pkg::REG_KEY_WORD3:  key_flat_r[3*rc4_pkg::KEY_WORD_W +: rc4_pkg::KEY_WORD_W] <= cfg_wdata;
          rc4_pkg::REG_KEY_LENGTH: key_len_r <= cfg_wdata[rc4_pkg::KEY_LEN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    sn_r       <= sn_nxt;
    sj_r       <= sj_nxt;
    t_r        <= t_nxt;
    data_r     <= data_nxt;
    pos_r      <= pos_nxt;
    out_byte_r <= out_byte_nxt;
    ks_r       <= ks_nxt;
  end

  assign sts.need_ks  = in_start_message | ~keyed_r;
  assign sts.n_last   = (n_r == 8'hFF);
  assign sts.out_free = ~out_valid_r | out_ready;

  assign out_valid          = out_valid_r;
  assign out_out_byte       = out_byte_r;
  assign out_keystream_byte = ks_r;

`ifndef NO_ASSERTIONS
  a_keyed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    keyed_r |=> keyed_r)
    else $error("keyed flag dropped without reset");

  a_fill_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == rc4_pkg::OP_KS_RD_N && $past(cmd.op) == rc4_pkg::OP_FILL) |-> (n_r == '0))
    else $error("key schedule started with nonzero index");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == rc4_pkg::OP_KS_RD_J) |->
      (rc4_pkg::KEY_LEN_W'(pos_r) < len_eff))
    else $error("key byte position beyond key length");
`endif

endmodule

`default_nettype wire

// ----- tb/rc4_stream_cipher_tb.sv -----
// Self-checking testbench for the RC4 stream cipher: keystream prediction, random traffic.
module rc4_stream_cipher_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT      = 2_000_000;
  localparam int unsigned DRAIN_CYCLES     = 8;
  localparam int unsigned LONG_HOLD        = 300;
  localparam int unsigned TARGET_ITEMS     = 400;
  localparam int unsigned MAX_KEY_BYTES_TB = 32;

  localparam logic [rc4_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_LO = rc4_pkg::REG_KEY_LENGTH + 1'b1;
  localparam logic [rc4_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_HI = {rc4_pkg::CFG_IDX_W{1'b1}};

  typedef struct packed {
    logic [rc4_pkg::BYTE_W-1:0] text;
    logic [rc4_pkg::BYTE_W-1:0] keystream;
  } cipher_result_t;

  // Tracks key registers and S-box state; holds pending cipher results.
  class cipher_checker;
    logic [rc4_pkg::KEY_WORD_W-1:0] key_words [rc4_pkg::KEY_WORDS];
    logic [rc4_pkg::KEY_LEN_W-1:0]  key_len;
    logic [rc4_pkg::BYTE_W-1:0]     perm [256];
    logic [rc4_pkg::BYTE_W-1:0]     idx_i, idx_j;
    bit                             keyed;
    cipher_result_t                 pending_results [$];
    int unsigned                    checked, mismatches, schedules;

    function new();
      foreach (key_words[n]) key_words[n] = '0;
      key_len    = rc4_pkg::KEY_LEN_RESET;
      idx_i      = '0;
      idx_j      = '0;
      keyed      = 1'b0;
      checked    = 0;
      mismatches = 0;
      schedules  = 0;
    endfunction

    function void write_reg(logic [rc4_pkg::CFG_IDX_W-1:0] idx,
                            logic [rc4_pkg::KEY_WORD_W-1:0] data);
      case (idx)
        rc4_pkg::REG_KEY_WORD0, rc4_pkg::REG_KEY_WORD1,
        rc4_pkg::REG_KEY_WORD2, rc4_pkg::REG_KEY_WORD3: key_words[idx[1:0]] = data;
        rc4_pkg::REG_KEY_LENGTH: key_len = data[rc4_pkg::KEY_LEN_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [rc4_pkg::BYTE_W-1:0] key_byte(int unsigned n);
      return key_words[2'((n >> 3) & 3)][(n & 7) * 8 +: 8];
    endfunction

    function void schedule_key();
      int unsigned                len, pos;
      logic [rc4_pkg::BYTE_W-1:0] j, tmp;
      len = int'(key_len);
      if (len == 0) len = 1;
      if (len > MAX_KEY_BYTES_TB) len = MAX_KEY_BYTES_TB;
      for (int n = 0; n < 256; n++) perm[n] = n[rc4_pkg::BYTE_W-1:0];
      j   = '0;
      pos = 0;
      for (int n = 0; n < 256; n++) begin
        j       = j + perm[n] + key_byte(pos);
        tmp     = perm[n];
        perm[n] = perm[j];
        perm[j] = tmp;
        pos++;
        if (pos >= len) pos = 0;
      end
      idx_i = '0;
      idx_j = '0;
      keyed = 1'b1;
      schedules++;
    endfunction

    function void note_item(logic [rc4_pkg::BYTE_W-1:0] data, logic start);
      logic [rc4_pkg::BYTE_W-1:0] tmp, t;
      cipher_result_t             res;
      if (start || !keyed) schedule_key();
      idx_i       = idx_i + 1'b1;
      idx_j       = idx_j + perm[idx_i];
      tmp         = perm[idx_i];
      perm[idx_i] = perm[idx_j];
      perm[idx_j] = tmp;
      t             = perm[idx_i] + perm[idx_j];
      res.keystream = perm[t];
      res.text      = data ^ res.keystream;
      pending_results = {pending_results, res};
    endfunction

    function void flag(string what, logic [rc4_pkg::BYTE_W-1:0] exp_v,
                       logic [rc4_pkg::BYTE_W-1:0] act_v);
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch in %s at result %0d: expected %02h, got %02h",
                 what, checked, exp_v, act_v);
    endfunction

    function void check_result(logic [rc4_pkg::BYTE_W-1:0] text,
                               logic [rc4_pkg::BYTE_W-1:0] ks);
      cipher_result_t exp_r;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %02h/%02h arrived with no item pending", text, ks);
        return;
      end
      exp_r = pending_results.pop_front();
      if (text !== exp_r.text) flag("out_byte", exp_r.text, text);
      if (ks !== exp_r.keystream) flag("keystream_byte", exp_r.keystream, ks);
      checked++;
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction

    function int unsigned failures();
      return mismatches + pending_results.size();
    endfunction
  endclass

  logic                           clk              = 1'b0;
  logic                           rst_n            = 1'b0;
  logic                           cfg_we           = 1'b0;
  logic [rc4_pkg::CFG_IDX_W-1:0]  cfg_index        = '0;
  logic [rc4_pkg::KEY_WORD_W-1:0] cfg_wdata        = '0;
  logic                           in_valid         = 1'b0;
  logic                           in_ready;
  logic [rc4_pkg::BYTE_W-1:0]     in_data_byte     = '0;
  logic                           in_start_message = 1'b0;
  logic                           out_valid;
  logic                           out_ready        = 1'b0;
  logic [rc4_pkg::BYTE_W-1:0]     out_out_byte;
  logic [rc4_pkg::BYTE_W-1:0]     out_keystream_byte;

  cipher_checker chk = new();

  bit          quiet       = 1'b0;
  bit          hold_req    = 1'b0;
  int unsigned items_sent  = 0;
  int unsigned key_setups  = 0;
  int unsigned cycle_count = 0;

  rc4_stream_cipher #(.MAX_KEY_BYTES(MAX_KEY_BYTES_TB)) DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_data_byte       (in_data_byte),
    .in_start_message   (in_start_message),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_out_byte       (out_out_byte),
    .out_keystream_byte (out_keystream_byte)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending", cycle_count, chk.pending());
      $display("TEST FAILED");
      $finish;
    end
  end

  // Mostly no gap, some short ones, a few long ones.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [rc4_pkg::KEY_WORD_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [rc4_pkg::BYTE_W-1:0] rand_byte();
    return rc4_pkg::BYTE_W'($urandom_range(0, 255));
  endfunction

  // Observe the ports at each edge; all drives are nonblocking, so these are pre-edge values.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) chk.write_reg(cfg_index, cfg_wdata);
      if (out_valid && out_ready) chk.check_result(out_out_byte, out_keystream_byte);
      if (in_valid && in_ready) chk.note_item(in_data_byte, in_start_message);
    end
  end

  // Result side back-pressure; a requested hold is counted here.
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0 && !quiet && $urandom_range(0, 7) == 0) begin
        stall_left = idle_len();
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
      @(posedge clk);
    end
  end

  task automatic send_item(input logic [rc4_pkg::BYTE_W-1:0] data, input logic start);
    int unsigned gap;
    in_valid         <= 1'b1;
    in_data_byte     <= data;
    in_start_message <= start;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    gap = quiet ? 0 : idle_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (chk.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [rc4_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rc4_pkg::KEY_WORD_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // Only called with the block idle.
  task automatic program_key(input logic [rc4_pkg::KEY_WORD_W-1:0] w0,
                             input logic [rc4_pkg::KEY_WORD_W-1:0] w1,
                             input logic [rc4_pkg::KEY_WORD_W-1:0] w2,
                             input logic [rc4_pkg::KEY_WORD_W-1:0] w3,
                             input logic [rc4_pkg::KEY_LEN_W-1:0] len);
    logic [rc4_pkg::KEY_WORD_W-1:0] junk;
    junk = rand_word();
    write_reg(rc4_pkg::REG_KEY_WORD0, w0);
    write_reg(rc4_pkg::REG_KEY_WORD1, w1);
    write_reg(rc4_pkg::REG_KEY_WORD2, w2);
    write_reg(rc4_pkg::REG_KEY_WORD3, w3);
    // upper data bits are don't-care for the length register
    write_reg(rc4_pkg::REG_KEY_LENGTH,
              {junk[rc4_pkg::KEY_WORD_W-1:rc4_pkg::KEY_LEN_W], len});
    // unmapped index must be ignored
    write_reg(rc4_pkg::CFG_IDX_W'($urandom_range(REG_UNMAPPED_LO, REG_UNMAPPED_HI)),
              rand_word());
    cfg_we <= 1'b0;
    @(posedge clk);
    key_setups++;
  endtask

  function automatic logic [rc4_pkg::KEY_LEN_W-1:0] pick_len();
    int unsigned r;
    r = $urandom_range(0, 9);
    case (r)
      0: return '0;
      1: return rc4_pkg::KEY_LEN_W'($urandom_range(MAX_KEY_BYTES_TB + 1,
                                                   (1 << rc4_pkg::KEY_LEN_W) - 1));
      2: return rc4_pkg::KEY_LEN_W'(MAX_KEY_BYTES_TB);
      3: return rc4_pkg::KEY_LEN_W'(1);
      default: return rc4_pkg::KEY_LEN_W'($urandom_range(1, MAX_KEY_BYTES_TB));
    endcase
  endfunction

  function automatic logic [rc4_pkg::KEY_WORD_W-1:0] pick_word(int unsigned flavor);
    if (flavor == 0) return '0;
    if (flavor == 1) return '1;
    return rand_word();
  endfunction

  initial begin
    int unsigned n_items, flavor, phase;
    logic        start;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Default key after reset; first item has no start flag but must still key up.
    quiet = 1'b1;
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'hA5, 1'b1);
    send_item(8'h5A, 1'b1);
    send_item(8'hFF, 1'b0);
    wait_drained();
    quiet = 1'b0;

    // Extreme keys: short ASCII key, all ones at full length, zero length, oversize length.
    for (int k = 0; k < 4; k++) begin
      case (k)
        0: program_key(64'h0000_0000_0079_654B, '0, '0, '0, 6'd3);
        1: program_key('1, '1, '1, '1, 6'd32);
        2: program_key(rand_word(), rand_word(), rand_word(), rand_word(), 6'd0);
        default: program_key(rand_word(), rand_word(), rand_word(), rand_word(), 6'd63);
      endcase
      send_item(8'h00, 1'b1);
      send_item(8'hFF, 1'b0);
      send_item(rand_byte(), 1'b0);
      wait_drained();
    end

    // New key loaded mid-message only applies at the next start.
    program_key(rand_word(), rand_word(), '0, '1, 6'd20);
    send_item(8'h3C, 1'b0);
    send_item(8'hC3, 1'b0);
    send_item(8'h00, 1'b1);
    wait_drained();

    // Long result-side hold while items keep coming, so the input backs up.
    quiet    = 1'b1;
    hold_req = 1'b1;
    for (int n = 0; n < 12; n++) send_item(rand_byte(), 1'b0);
    wait_drained();
    quiet = 1'b0;

    phase = 0;
    while (items_sent < TARGET_ITEMS) begin
      flavor = $urandom_range(0, 9);
      program_key(pick_word(flavor), pick_word(flavor), pick_word(flavor), pick_word(flavor),
                  pick_len());
      quiet   = ($urandom_range(0, 4) == 0);
      n_items = $urandom_range(15, 50);
      for (int n = 0; n < n_items; n++) begin
        if (n == 0) start = ($urandom_range(0, 3) != 0);
        else        start = ($urandom_range(0, 29) == 0);
        send_item(rand_byte(), start);
      end
      wait_drained();
      phase++;
    end
    quiet = 1'b0;

    wait_drained();
    repeat (20) @(posedge clk);
    $display("Covered %0d bytes under %0d key setups (%0d random phases), %0d key schedules.",
             items_sent, key_setups, phase, chk.schedules);
    $display("Checked %0d results, %0d mismatches, %0d left unmatched.",
             chk.checked, chk.mismatches, chk.pending());
    if (chk.failures() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- rc4_stream_cipher.f -----
sv/rc4_pkg.sv
sv/rc4_ctrl.sv
sv/rc4_dp.sv
sv/rc4_stream_cipher.sv
tb/rc4_stream_cipher_tb.sv
